/* rtl/connection_id_table_match_macros.svh */
// Assertion macros shared by the connection ID table RTL.
`ifndef CONNECTION_ID_TABLE_MATCH_MACROS_SVH
`define CONNECTION_ID_TABLE_MATCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CIDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CIDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cidm_pkg.sv */
// Shared types and constants for the connection ID table match block.
package cidm_pkg;

  // Field widths fixed by the item format
  localparam int LEN_W      = 5;
  localparam int HDR_BYTES  = 20;
  localparam int HDR_W      = 8 * HDR_BYTES;
  localparam int IN_DATA_W  = 176;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 8;

  // Short header bits of the first byte
  localparam int HDR_FORM_BIT  = 7;
  localparam int HDR_FIXED_BIT = 6;

  // Command and table select codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;
  localparam logic TAB_PEER   = 1'b0;
  localparam logic TAB_OWN    = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_LOOKUP   = 3'd0,
    ST_INSERTED = 3'd1,
    ST_PRESENT  = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_FULL     = 3'd4
  } cidm_status_t;

  // Table memory control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic tab;
  } cidm_mem_ctl_t;

endpackage

/* rtl/cidm_cmp.sv */
// Shared entry compare unit: masked byte compare of a stored ID against the key.
module cidm_cmp #(
  parameter int ID_MAX_BYTES = 20
) (
  input  logic [cidm_pkg::LEN_W+8*ID_MAX_BYTES-1:0] ent,
  input  logic [8*ID_MAX_BYTES-1:0]                 key,
  input  logic [cidm_pkg::LEN_W-1:0]                key_len,
  input  logic                                      exact,
  output logic                                      hit
);
  import cidm_pkg::*;

  logic [LEN_W-1:0]          ent_len;
  logic [8*ID_MAX_BYTES-1:0] ent_bytes;
  logic                      bytes_eq;

  assign ent_len   = ent[LEN_W+8*ID_MAX_BYTES-1 -: LEN_W];
  assign ent_bytes = ent[8*ID_MAX_BYTES-1:0];

  // bytes below the stored length must agree
  always_comb begin
    bytes_eq = 1'b1;
    for (int i = 0; i < ID_MAX_BYTES; i++) begin
      if ((LEN_W'(i) < ent_len) && (ent_bytes[8*i +: 8] != key[8*i +: 8])) begin
        bytes_eq = 1'b0;
      end
    end
  end

  // insert needs equal length too, lookup is a prefix test
  assign hit = exact ? ((ent_len == key_len) && bytes_eq) : bytes_eq;

endmodule

/* rtl/cidm_store.sv */
// Own and peer ID table memories with their entry counts.
module cidm_store #(
  parameter int  TABLE_DEPTH  = 8,
  parameter int  ID_MAX_BYTES = 20,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int ENT_W = cidm_pkg::LEN_W + 8 * ID_MAX_BYTES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cidm_pkg::cidm_mem_ctl_t ctl,
  input  logic [IDX_W-1:0]        rd_addr,
  input  logic [ENT_W-1:0]        wr_ent,
  output logic [ENT_W-1:0]        rd_ent,
  output logic [CNT_W-1:0]        own_cnt,
  output logic [CNT_W-1:0]        peer_cnt
);
  import cidm_pkg::*;

  logic [ENT_W-1:0] own_mem  [TABLE_DEPTH];
  logic [ENT_W-1:0] peer_mem [TABLE_DEPTH];
  logic [ENT_W-1:0] own_q_r;
  logic [ENT_W-1:0] peer_q_r;
  logic             rd_sel_r;
  logic [CNT_W-1:0] own_cnt_r,  own_cnt_nxt;
  logic [CNT_W-1:0] peer_cnt_r, peer_cnt_nxt;

  // own table: append at count, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.tab == TAB_OWN)) begin
      own_mem[own_cnt_r[IDX_W-1:0]] <= wr_ent;
    end
    if (ctl.rd_en) begin
      own_q_r <= own_mem[rd_addr];
    end
  end

  // peer table: append at count, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.tab == TAB_PEER)) begin
      peer_mem[peer_cnt_r[IDX_W-1:0]] <= wr_ent;
    end
    if (ctl.rd_en) begin
      peer_q_r <= peer_mem[rd_addr];
    end
  end

  // read data select follows the table of the read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_sel_r <= ctl.tab;
    end
  end

  assign rd_ent = (rd_sel_r == TAB_OWN) ? own_q_r : peer_q_r;

  // entry counts
  always_comb begin
    own_cnt_nxt  = own_cnt_r;
    peer_cnt_nxt = peer_cnt_r;
    if (ctl.wr_en) begin
      if (ctl.tab == TAB_OWN) begin
        own_cnt_nxt = own_cnt_r + 1'b1;
      end else begin
        peer_cnt_nxt = peer_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_cnt_r  <= '0;
      peer_cnt_r <= '0;
    end else begin
      own_cnt_r  <= own_cnt_nxt;
      peer_cnt_r <= peer_cnt_nxt;
    end
  end

  assign own_cnt  = own_cnt_r;
  assign peer_cnt = peer_cnt_r;

`include "connection_id_table_match_macros.svh"

  `CIDM_ASSERT_IMP(a_wr_room, ctl.wr_en, ((ctl.tab == TAB_OWN) ? own_cnt_r : peer_cnt_r) < CNT_W'(TABLE_DEPTH), "write into a full table")
  `CIDM_ASSERT_IMP(a_rd_in_use, ctl.rd_en, CNT_W'(rd_addr) < ((ctl.tab == TAB_OWN) ? own_cnt_r : peer_cnt_r), "read beyond entries in use")
  `CIDM_ASSERT_NXT(a_own_bump, ctl.wr_en && (ctl.tab == TAB_OWN), own_cnt_r == CNT_W'($past(own_cnt_r) + 1'b1), "own count not bumped by write")

endmodule

/* rtl/connection_id_table_match.sv */
// Top level: sequencer walking the ID tables through the shared compare unit.
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata 176b, in_tuser 3b
//  out_    | master    | out_tvalid/out_tready| out_tdata 8b
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_data 1b (train_mode)
//
// Flow: an item is accepted, then the walk reads one table entry per cycle through the
//   registered memory read and the compare unit, stopping early on a hit (a send in
//   training mode may walk both tables); then the result is posted.
//   Too long inserts, long headers and sends with an empty peer table skip the walk.
// Reset clears the entry counts, train_mode and control; table memories are not cleared.
// The result sits in an output register; a new item is accepted while it waits, but
//   that item's result is held until the output register is free.
module connection_id_table_match #(
  parameter int  TABLE_DEPTH  = 8,
  parameter int  ID_MAX_BYTES = 20,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int KEY_W = 8 * ID_MAX_BYTES,
  localparam int ENT_W = cidm_pkg::LEN_W + KEY_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: id_len[4:0], first_byte[12:5], id_bytes_hi[76:13],
  //           id_bytes_mid[140:77], id_bytes_lo[172:141], zero pad
  input  logic [cidm_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: cmd[0], table_sel[1], is_recv[2]
  input  logic [cidm_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: matched[0], status[3:1], zero pad
  output logic [cidm_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready
);
  import cidm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic             cmd_r, cmd_nxt;
  logic             tab_r, tab_nxt;
  logic             recv_r, recv_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [LEN_W-1:0] key_len_r, key_len_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             pend_r, pend_nxt;
  logic             res_match_r, res_match_nxt;
  cidm_status_t     res_status_r, res_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_match_r, out_match_nxt;
  cidm_status_t     out_status_r, out_status_nxt;
  logic             train_r;

  logic [LEN_W-1:0] in_id_len;
  logic [7:0]       in_first;
  logic [HDR_W-1:0] in_hdr;
  logic             in_cmd, in_tab, in_recv;
  logic             in_acc;
  logic             short_hdr;

  cidm_mem_ctl_t    ctl;
  logic [ENT_W-1:0] rd_ent;
  logic [CNT_W-1:0] own_cnt, peer_cnt, cur_cnt;
  logic             issue, hit, cmp_hit, tab_end, tab_full;

  // unpack the input transaction
  assign in_id_len = in_tdata[4:0];
  assign in_first  = in_tdata[12:5];
  assign in_hdr    = {in_tdata[76:13], in_tdata[140:77], in_tdata[172:141]};
  assign in_cmd    = in_tuser[0];
  assign in_tab    = in_tuser[1];
  assign in_recv   = in_tuser[2];

  // no transaction is taken while reset is held
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign short_hdr = !in_first[HDR_FORM_BIT] && in_first[HDR_FIXED_BIT];

  // key byte i sits at bits [8*i +: 8]
  always_comb begin
    key_nxt = key_r;
    if (in_acc) begin
      for (int i = 0; i < ID_MAX_BYTES; i++) begin
        key_nxt[8*i +: 8] = in_hdr[HDR_W-1-8*i -: 8];
      end
    end
  end

  // walk status
  assign cur_cnt  = (tab_r == TAB_OWN) ? own_cnt : peer_cnt;
  assign issue    = (rd_idx_r < cur_cnt);
  assign hit      = pend_r && cmp_hit;
  assign tab_end  = hit || (!issue && !pend_r);
  assign tab_full = (cur_cnt == CNT_W'(TABLE_DEPTH));

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    tab_nxt        = tab_r;
    recv_nxt       = recv_r;
    key_len_nxt    = key_len_r;
    rd_idx_nxt     = rd_idx_r;
    pend_nxt       = pend_r;
    res_match_nxt  = res_match_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_match_nxt  = out_match_r;
    out_status_nxt = out_status_r;
    ctl            = '0;
    ctl.tab        = tab_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = in_cmd;
          recv_nxt       = in_recv;
          key_len_nxt    = in_id_len;
          rd_idx_nxt     = '0;
          pend_nxt       = 1'b0;
          res_match_nxt  = 1'b0;
          res_status_nxt = ST_LOOKUP;
          if (in_cmd == CMD_INSERT) begin
            tab_nxt = in_tab;
            if (in_id_len > LEN_W'(ID_MAX_BYTES)) begin
              res_status_nxt = ST_TOO_LONG;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_WALK;
            end
          end else if (!short_hdr) begin
            state_nxt = S_DONE;
          end else if (in_recv) begin
            tab_nxt   = TAB_OWN;
            state_nxt = S_WALK;
          end else if (peer_cnt == '0) begin
            state_nxt = S_DONE;
          end else begin
            tab_nxt   = TAB_PEER;
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        // read one entry ahead, compare the one read last cycle
        ctl.rd_en = issue && !hit;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        pend_nxt = issue;
        if (tab_end) begin
          if (cmd_r == CMD_INSERT) begin
            state_nxt = S_DONE;
            if (hit) begin
              res_status_nxt = ST_PRESENT;
            end else if (tab_full) begin
              res_status_nxt = ST_FULL;
            end else begin
              ctl.wr_en      = 1'b1;
              res_status_nxt = ST_INSERTED;
            end
          end else if (hit) begin
            res_match_nxt = 1'b1;
            state_nxt     = S_DONE;
          end else if (!recv_r && (tab_r == TAB_PEER) && train_r) begin
            // training mode: send lookups fall back to the own table
            tab_nxt    = TAB_OWN;
            rd_idx_nxt = '0;
            pend_nxt   = 1'b0;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_match_nxt  = res_match_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      train_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        train_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    tab_r        <= tab_nxt;
    recv_r       <= recv_nxt;
    key_r        <= key_nxt;
    key_len_r    <= key_len_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_match_r  <= res_match_nxt;
    res_status_r <= res_status_nxt;
    out_match_r  <= out_match_nxt;
    out_status_r <= out_status_nxt;
  end

  assign cfg_ready  = rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_status_r, out_match_r};

  cidm_store #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .ID_MAX_BYTES (ID_MAX_BYTES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_addr  (rd_idx_r[IDX_W-1:0]),
    .wr_ent   ({key_len_r, key_r}),
    .rd_ent   (rd_ent),
    .own_cnt  (own_cnt),
    .peer_cnt (peer_cnt)
  );

  cidm_cmp #(
    .ID_MAX_BYTES (ID_MAX_BYTES)
  ) u_cmp (
    .ent     (rd_ent),
    .key     (key_r),
    .key_len (key_len_r),
    .exact   (cmd_r == CMD_INSERT),
    .hit     (cmp_hit)
  );

`include "connection_id_table_match_macros.svh"

  `CIDM_ASSERT_NXT(a_acc_busy, in_tvalid && in_tready, state_r != S_IDLE, "accepted item left no work")
  `CIDM_ASSERT_IMP(a_insert_nomatch, out_tvalid && (out_status_r != ST_LOOKUP), !out_match_r, "insert result flagged as match")
  `CIDM_ASSERT_NXT(a_wr_then_done, ctl.wr_en, state_r == S_DONE, "table write not followed by result")

endmodule
